// ----- sv/bucket_hash_double_hashing_unit_assert.svh -----
// Assertion macros for the bucket hash unit.
// Expects signals clk and rst in the scope where a macro is used.
`ifndef BUCKET_HASH_DOUBLE_HASHING_UNIT_ASSERT_SVH
`define BUCKET_HASH_DOUBLE_HASHING_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BHDH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BHDH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bhdh_pkg.sv -----
// Types and fixed constants of the bucket hash unit.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package bhdh_pkg;

  // Operation codes of a request transaction.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result codes.
  localparam logic [2:0] RES_INSERTED  = 3'd0;
  localparam logic [2:0] RES_FOUND     = 3'd1;
  localparam logic [2:0] RES_NOT_FOUND = 3'd2;
  localparam logic [2:0] RES_DELETED   = 3'd3;
  localparam logic [2:0] RES_FULL      = 3'd4;

  // Slot tags.
  localparam logic [1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [1:0] SLOT_USED    = 2'd1;
  localparam logic [1:0] SLOT_DELETED = 2'd2;

  localparam logic [10:0] COUNT_MAX = 11'h7FF;

  // A 31-bit key has four base-1000 digits; their sum stays below 3000.
  localparam int         SUM_W      = 12;
  localparam logic [1:0] DIGIT_LAST = 2'd3;

  // Reciprocals for exact division by constants: q = (x * M) >> shift.
  localparam logic [31:0] M_DIV1000 = 32'd2199023256;  // 31-bit x, shift 41
  localparam logic [31:0] M_DIV100K = 32'd2814749768;  // 31-bit x, shift 48
  localparam logic [31:0] M_DIV3125 = 32'd703687442;   // 29-bit x, shift 41
  localparam logic [31:0] M_DIV100  = 32'd167773;      // 17-bit x, shift 24
  localparam logic [31:0] C_1000    = 32'd1000;
  localparam logic [31:0] C_100K    = 32'd100000;

  typedef struct packed {
    logic [1:0]  operation;
    logic [30:0] key;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_payload;
    logic [10:0] probe_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  tag;
    logic [30:0] key;
    logic [31:0] payload;
  } slot_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_HDIV,
    S_HMUL,
    S_HACC,
    S_RDIV,
    S_RMUL,
    S_RSUB,
    S_KDIV,
    S_KMUL,
    S_KSUB,
    S_SQ,
    S_SQDIV,
    S_SQMUL,
    S_SQSUB,
    S_MID,
    S_MIDQ,
    S_SCALE1,
    S_SCALE2,
    S_SCALE3,
    S_RD,
    S_CHK,
    S_DONE
  } state_t;

endpackage

// ----- sv/bucket_hash_double_hashing_unit.sv -----
// Open-addressing hash store with double hashing, one transaction at a time.
// Depends on bhdh_pkg and bucket_hash_double_hashing_unit_assert.svh.
//
// After reset the store is swept once to mark every slot empty, all
// BUCKETS*SLOTS_PER_BUCKET slots (1994 by default); requests are stalled
// until it finishes. An insert, search or delete then first computes the
// home bucket (digit sum, mod BUCKETS) and the probe step (middle digits of
// the square, mod BUCKETS) on one shared 32x32 multiplier, and then examines
// slots, each with a store read followed by a check state that may write
// back. An unused operation code goes straight to the final state. While an
// earlier result is still stalled in the output register, the sequencer
// waits in its final state until that result is taken. The result sits in an
// output register, so a new request may be taken while the previous result
// is still stalled.
`timescale 1ns / 1ps
`include "bucket_hash_double_hashing_unit_assert.svh"

module bucket_hash_double_hashing_unit #(
  parameter int BUCKETS          = 997,
  parameter int SLOTS_PER_BUCKET = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  bhdh_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output bhdh_pkg::rsp_t  rsp
);
  import bhdh_pkg::*;

  localparam int TOTAL  = BUCKETS * SLOTS_PER_BUCKET;
  localparam int AW     = $clog2(TOTAL);
  localparam int BW     = $clog2(BUCKETS);
  localparam int SW     = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
  localparam int RED_SH = SUM_W + BW;
  localparam longint unsigned RED_M =
    ((64'd1 << RED_SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_BUCKET - 1);
  localparam logic [AW:0]   TOTAL_X   = (AW + 1)'(TOTAL);

  state_t state, state_next;

  // Request and working registers.
  logic [1:0]       op_r;
  logic [30:0]      key_r;
  logic [31:0]      payload_r;
  logic [30:0]      cur;
  logic [21:0]      quo;
  logic [1:0]       dcnt;
  logic [SUM_W-1:0] val;
  logic             red_home;
  logic [33:0]      w;
  logic [63:0]      prod;
  logic [BW-1:0]    home;
  logic [BW-1:0]    step;
  logic [AW-1:0]    home_base;
  logic [AW-1:0]    base;
  logic [AW-1:0]    step_s;
  logic [SW-1:0]    slot;
  logic [AW-1:0]    addr_r;
  logic [AW-1:0]    clr;
  logic [2:0]       res_status;
  logic [31:0]      res_payload;
  logic [10:0]      count;

  // Shared multiplier operands.
  logic [31:0] mul_a, mul_b;

  // Slot store.
  slot_t         mem [TOTAL];
  slot_t         rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_t         mem_wdata;
  logic [AW-1:0] rd_addr;

  // Probe decision.
  logic          key_match, take_ins, hit, stop_empty, last_slot, wrapped, chk_done;
  logic [AW:0]   nb_sum;
  logic [AW-1:0] nb;
  logic [SUM_W-1:0] red;

  always_ff @(posedge clk) begin
    prod <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.operation == OP_UNUSED) ? S_DONE : S_HDIV;
        end
      end
      S_HDIV:   state_next = S_HMUL;
      S_HMUL:   state_next = S_HACC;
      S_HACC:   state_next = (dcnt == DIGIT_LAST) ? S_RDIV : S_HDIV;
      S_RDIV:   state_next = S_RMUL;
      S_RMUL:   state_next = S_RSUB;
      S_RSUB:   state_next = red_home ? S_KDIV : S_SCALE1;
      S_KDIV:   state_next = S_KMUL;
      S_KMUL:   state_next = S_KSUB;
      S_KSUB:   state_next = S_SQ;
      S_SQ:     state_next = S_SQDIV;
      S_SQDIV:  state_next = S_SQMUL;
      S_SQMUL:  state_next = S_SQSUB;
      S_SQSUB:  state_next = S_MID;
      S_MID:    state_next = S_MIDQ;
      S_MIDQ:   state_next = S_RDIV;
      S_SCALE1: state_next = S_SCALE2;
      S_SCALE2: state_next = S_SCALE3;
      S_SCALE3: state_next = S_RD;
      S_RD:     state_next = S_CHK;
      S_CHK:    state_next = chk_done ? S_DONE : S_RD;
      S_DONE:   if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: multiplier operands, store access, decisions.
  always_comb begin
    req_stall = (state != S_IDLE);

    key_match  = (rdata.tag == SLOT_USED) && (rdata.key == key_r);
    take_ins   = (op_r == OP_INSERT) && (rdata.tag != SLOT_USED);
    hit        = (op_r != OP_INSERT) && key_match;
    stop_empty = (op_r != OP_INSERT) && (rdata.tag == SLOT_EMPTY);
    last_slot  = (slot == LAST_SLOT);
    nb_sum     = {1'b0, base} + {1'b0, step_s};
    nb         = (nb_sum >= TOTAL_X) ? AW'(nb_sum - TOTAL_X) : nb_sum[AW-1:0];
    wrapped    = last_slot && (nb == home_base);
    chk_done   = take_ins || hit || stop_empty || wrapped;
    red        = val - prod[SUM_W-1:0];

    rd_addr   = base + AW'(slot);
    mem_we    = 1'b0;
    mem_waddr = addr_r;
    mem_wdata = '0;

    mul_a = '0;
    mul_b = '0;

    unique case (state)
      S_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr;
        mem_wdata.tag = SLOT_EMPTY;
      end
      S_HDIV: begin
        mul_a = 32'(cur);
        mul_b = M_DIV1000;
      end
      S_HMUL: begin
        mul_a = 32'(prod[62:41]);
        mul_b = C_1000;
      end
      S_RDIV: begin
        mul_a = 32'(val);
        mul_b = 32'(RED_M);
      end
      S_RMUL: begin
        mul_a = 32'(prod[RED_SH +: SUM_W]);
        mul_b = 32'(BUCKETS);
      end
      S_KDIV: begin
        mul_a = 32'(key_r);
        mul_b = M_DIV100K;
      end
      S_KMUL: begin
        mul_a = 32'(prod[62:48]);
        mul_b = C_100K;
      end
      S_SQ: begin
        mul_a = 32'(w[16:0]);
        mul_b = 32'(w[16:0]);
      end
      S_SQDIV: begin
        // Dividing the square by 100000 is a shift by 5 and a divide by 3125.
        mul_a = 32'(prod[33:5]);
        mul_b = M_DIV3125;
      end
      S_SQMUL: begin
        mul_a = 32'(prod[57:41]);
        mul_b = C_100K;
      end
      S_MID: begin
        mul_a = 32'(w[16:0]);
        mul_b = M_DIV100;
      end
      S_SCALE1: begin
        mul_a = 32'(home);
        mul_b = 32'(SLOTS_PER_BUCKET);
      end
      S_SCALE2: begin
        mul_a = 32'(step);
        mul_b = 32'(SLOTS_PER_BUCKET);
      end
      S_CHK: begin
        if (take_ins) begin
          mem_we    = 1'b1;
          mem_wdata = '{tag: SLOT_USED, key: key_r, payload: payload_r};
        end else if (hit && (op_r == OP_DELETE)) begin
          mem_we    = 1'b1;
          mem_wdata = '{tag: SLOT_DELETED, key: rdata.key, payload: rdata.payload};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_r        <= req.operation;
        key_r       <= req.key;
        payload_r   <= req.payload;
        cur         <= req.key;
        val         <= '0;
        dcnt        <= '0;
        red_home    <= 1'b1;
        count       <= '0;
        res_payload <= '0;
        res_status  <= (req.operation == OP_INSERT) ? RES_FULL : RES_NOT_FOUND;
      end
      S_HMUL: quo <= prod[62:41];
      S_HACC: begin
        // The product holds the quotient times 1000; the difference is a digit.
        val  <= val + SUM_W'(cur - prod[30:0]);
        cur  <= 31'(quo);
        dcnt <= dcnt + 2'd1;
      end
      S_RSUB: begin
        if (red_home) begin
          home <= red[BW-1:0];
        end else begin
          step <= red[BW-1:0];
        end
      end
      // Only the key modulo 100000 matters for the middle digits of its square.
      S_KSUB:   w <= 34'(key_r - prod[30:0]);
      S_SQDIV:  w <= prod[33:0];
      S_SQSUB:  w <= w - prod[33:0];
      S_MIDQ: begin
        val      <= SUM_W'(prod[33:24]);
        red_home <= 1'b0;
      end
      S_SCALE2: begin
        home_base <= prod[AW-1:0];
        base      <= prod[AW-1:0];
      end
      S_SCALE3: begin
        step_s <= prod[AW-1:0];
        slot   <= '0;
      end
      S_RD: addr_r <= rd_addr;
      S_CHK: begin
        if (count != COUNT_MAX) begin
          count <= count + 11'd1;
        end
        if (take_ins) begin
          res_status <= RES_INSERTED;
        end else if (hit) begin
          if (op_r == OP_SEARCH) begin
            res_status  <= RES_FOUND;
            res_payload <= rdata.payload;
          end else begin
            res_status <= RES_DELETED;
          end
        end
        if (!chk_done) begin
          if (last_slot) begin
            base <= nb;
            slot <= '0;
          end else begin
            slot <= slot + SW'(1);
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp <= '{status: res_status, found_payload: res_payload, probe_count: count};
        end
      end
      default: begin
      end
    endcase
  end

  `BHDH_ASSERT_IMP(a_probe_in_range, state == S_RD, 32'(base) < 32'(TOTAL), "probe base beyond store")
  `BHDH_ASSERT_IMP(a_hash_reduced, state == S_SCALE1, (32'(home) < 32'(BUCKETS)) && (32'(step) < 32'(BUCKETS)), "home or step not reduced")
  `BHDH_ASSERT_IMP(a_payload_only_found, rsp_valid && (rsp.status != RES_FOUND), rsp.found_payload == 32'd0, "payload on a result other than found")
  `BHDH_ASSERT_IMP(a_store_write_phase, mem_we, (state == S_CLEAR) || (state == S_CHK), "store written outside sweep or check")
  `BHDH_ASSERT_NXT(a_accept_starts_hash, req_valid && !req_stall && (req.operation != OP_UNUSED), (state == S_HDIV) && (val == '0), "accepted request did not start hashing")

endmodule
